// ===== rtl/core/bspe_pkg.sv =====
package bspe_pkg;

    // Default sizes
    localparam int unsigned DEF_MAX_NODES  = 128;
    localparam int unsigned DEF_MAX_DEGREE = 128;
    localparam int unsigned DEF_MAX_BUDGET = 128;
    localparam int unsigned DEF_HEAP_DEPTH = 16384;

    // Field widths
    localparam int unsigned NODE_W   = 8;
    localparam int unsigned LEN_W    = 7;
    localparam int unsigned DNG_W    = 14;
    localparam int unsigned DANGER_W = 24;

    // Danger sums saturate one below the unreached mark
    localparam logic [DANGER_W-1:0] DANGER_INF = 24'hFFFFFF;
    localparam logic [DANGER_W-1:0] DANGER_MAX = 24'hFFFFFE;

    // Operation codes
    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_SOLVE    = 1'b1;

    // Register indexes
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_BUDGET     = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EDGE_RD_A,
        ST_EDGE_WR_A,
        ST_EDGE_RD_B,
        ST_EDGE_WR_B,
        ST_CLEAR,
        ST_INIT,
        ST_POP,
        ST_POP_TOP,
        ST_POP_XKEY,
        ST_SD_KEYX,
        ST_SD_L,
        ST_SD_LH,
        ST_SD_LK,
        ST_SD_R,
        ST_SD_RH,
        ST_SD_RK,
        ST_SD_MOVE,
        ST_CUR_RD,
        ST_CUR_CHK,
        ST_EX_RD,
        ST_EX_ADJ,
        ST_EX_WK,
        ST_EX_ES,
        ST_EX_EK,
        ST_EX_NEXT,
        ST_PU_START,
        ST_PU_CHK,
        ST_PU_PH,
        ST_PU_PK,
        ST_FINISH
    } bspe_state_t;

endpackage

// ===== rtl/core/bspe_ram.sv =====
module bspe_ram
    import bspe_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, register the read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/budgeted_shortest_path_engine.sv =====
// Budgeted shortest path engine.
// Input channel (s_*): one transaction per item. An add-edge item appends the
// edge to both endpoints' adjacency tables; it gives no result. A solve item
// runs Dijkstra over (node, remaining budget) states from node 1 to node
// node_count (clamped into 1..MAX_NODES) and gives one result on the m_*
// channel. A solve first sweeps the best-danger memory, one entry per cycle,
// over MAX_NODES rounded up to a power of two times MAX_BUDGET rounded up to
// a power of two entries (16384 by default). The search then pops the heap
// with a sift-down, reads each adjacency entry of the popped state and
// pushes every improved state with a sift-up. All heap, best-danger and
// adjacency state sits in memories with one read and one write port, so
// each step waits on one read. s_ready is high only while the engine is
// idle. Configuration goes through the APB port (node_count at 0x0, budget
// at 0x4); the user is to write it only while idle, and the block itself
// does not enforce this. A result waits in the output register; the next
// item is taken meanwhile, and a solve that finishes while the old result is
// still stalled holds until m_ready takes it. Reset empties all adjacency
// tables, clears m_valid and sets node_count to 2 and budget to 0.
module budgeted_shortest_path_engine
    import bspe_pkg::*;
#(
    parameter int unsigned MAX_NODES  = DEF_MAX_NODES,
    parameter int unsigned MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int unsigned MAX_BUDGET = DEF_MAX_BUDGET,
    parameter int unsigned HEAP_DEPTH = DEF_HEAP_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_operation,
    input  logic [NODE_W-1:0]    s_node_a,
    input  logic [NODE_W-1:0]    s_node_b,
    input  logic [LEN_W-1:0]     s_edge_length,
    input  logic [DNG_W-1:0]     s_edge_danger,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DANGER_W-1:0]  m_least_danger,
    output logic                 m_reached,
    output logic                 m_heap_overflow,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int unsigned NW  = $clog2(MAX_NODES);
    localparam int unsigned RW  = (MAX_BUDGET > 1) ? $clog2(MAX_BUDGET) : 1;
    localparam int unsigned DW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int unsigned CW  = $clog2(MAX_DEGREE + 1);
    localparam int unsigned HW  = $clog2(HEAP_DEPTH);
    localparam int unsigned HCW = $clog2(HEAP_DEPTH + 1);
    localparam int unsigned SW  = NW + RW;
    localparam int unsigned AW  = NW + DW;
    localparam int unsigned ADJ_W = NW + LEN_W + DNG_W;

    // Configuration registers
    logic [NODE_W-1:0] node_count_reg;
    logic [LEN_W-1:0]  budget_reg;

    bspe_state_t state_reg, state_next, ret_reg;

    // Item and search registers
    logic [NW-1:0]     a_idx_reg, b_idx_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [DNG_W-1:0]  dng_reg;
    logic [NW-1:0]     goal_reg;
    logic [RW-1:0]     start_rem_reg;
    logic [SW-1:0]     clr_cnt_reg;
    logic [HCW-1:0]    count_reg;
    logic [HCW-1:0]    i_reg;
    logic [SW-1:0]     x_reg, cand_reg, ment_reg, pitem_reg;
    logic [DANGER_W-1:0] xkey_reg, mkey_reg, pkey_reg, cur_reg, ans_reg;
    logic [HCW-1:0]    midx_reg;
    logic [NW-1:0]     s_node_reg, e_reg;
    logic [RW-1:0]     m_rem_reg;
    logic [CW-1:0]     deg_reg, j_reg;
    logic              reached_reg, ovf_reg;
    logic [MAX_NODES-1:0] deg_vld_reg;

    // Result register
    logic                m_valid_reg;
    logic [DANGER_W-1:0] m_danger_reg;
    logic                m_reached_reg, m_ovf_reg;

    // Memory ports
    logic                heap_we;
    logic [HW-1:0]       heap_waddr, heap_raddr;
    logic [SW-1:0]       heap_wdata, heap_rdata;
    logic                best_we;
    logic [SW-1:0]       best_waddr, best_raddr;
    logic [DANGER_W-1:0] best_wdata, best_rdata;
    logic                adj_we;
    logic [AW-1:0]       adj_waddr, adj_raddr;
    logic [ADJ_W-1:0]    adj_wdata, adj_rdata;
    logic                deg_we;
    logic [NW-1:0]       deg_waddr, deg_raddr;
    logic [CW-1:0]       deg_wdata, deg_rdata;

    // Derived values
    logic              in_fire, cfg_wr;
    logic              a_ok, b_ok;
    logic [8:0]        goal_ext;
    logic [HCW:0]      l_idx, r_idx;
    logic              l_ok, r_ok;
    logic [CW-1:0]     deg_a_val, deg_b_val;
    logic [CW-1:0]     deg_s_val;
    logic [DANGER_W:0] walk_sum;
    logic [DANGER_W-1:0] walk_key;
    logic              esc_ok;
    logic [RW-1:0]     esc_rem;
    logic [HCW-1:0]    parent_idx;
    logic              out_free;
    logic [NW-1:0]     adj_to;
    logic [LEN_W-1:0]  adj_len;
    logic [DNG_W-1:0]  adj_dng;

    assign in_fire = s_valid && s_ready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_BUDGET) ? 32'(budget_reg) : 32'(node_count_reg);

    assign a_ok = (s_node_a != '0) && ({1'b0, s_node_a} <= 9'(MAX_NODES));
    assign b_ok = (s_node_b != '0) && ({1'b0, s_node_b} <= 9'(MAX_NODES));

    // Clamp the goal into the node range
    always_comb begin
        goal_ext = (node_count_reg == '0) ? 9'd1 : {1'b0, node_count_reg};
        if (goal_ext > 9'(MAX_NODES)) begin
            goal_ext = 9'(MAX_NODES);
        end
    end

    assign l_idx      = {i_reg, 1'b0};
    assign r_idx      = l_idx + 1'b1;
    assign l_ok       = (l_idx < {1'b0, count_reg}) && (l_idx != {1'b0, i_reg});
    assign r_ok       = (r_idx < {1'b0, count_reg});
    assign parent_idx = i_reg >> 1;

    assign deg_a_val = deg_vld_reg[a_idx_reg]  ? deg_rdata : '0;
    assign deg_b_val = deg_vld_reg[b_idx_reg]  ? deg_rdata : '0;
    assign deg_s_val = deg_vld_reg[s_node_reg] ? deg_rdata : '0;

    assign {adj_to, adj_len, adj_dng} = adj_rdata;

    // Saturating walk cost and escort budget
    assign walk_sum = {1'b0, cur_reg} + (DANGER_W+1)'(dng_reg);
    assign walk_key = (walk_sum > {1'b0, DANGER_MAX}) ? DANGER_MAX : walk_sum[DANGER_W-1:0];
    assign esc_ok   = (9'(len_reg) <= 9'(m_rem_reg));
    assign esc_rem  = RW'(9'(m_rem_reg) - 9'(len_reg));

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_operation == OP_SOLVE) begin
                        state_next = ST_CLEAR;
                    end else if (a_ok && b_ok) begin
                        state_next = ST_EDGE_RD_A;
                    end
                end
            end
            ST_EDGE_RD_A: state_next = ST_EDGE_WR_A;
            ST_EDGE_WR_A: state_next = ST_EDGE_RD_B;
            ST_EDGE_RD_B: state_next = ST_EDGE_WR_B;
            ST_EDGE_WR_B: state_next = ST_IDLE;
            ST_CLEAR: begin
                if (clr_cnt_reg == '1) begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT: state_next = ST_POP;
            ST_POP: state_next = (count_reg == '0) ? ST_FINISH : ST_POP_TOP;
            ST_POP_TOP: state_next = (count_reg == HCW'(1)) ? ST_CUR_RD : ST_POP_XKEY;
            ST_POP_XKEY: state_next = ST_SD_KEYX;
            ST_SD_KEYX: state_next = ST_SD_L;
            ST_SD_L: begin
                if (l_ok) begin
                    state_next = ST_SD_LH;
                end else if (r_ok) begin
                    state_next = ST_SD_R;
                end else begin
                    state_next = ST_SD_MOVE;
                end
            end
            ST_SD_LH: state_next = ST_SD_LK;
            ST_SD_LK: state_next = ST_SD_R;
            ST_SD_R: state_next = r_ok ? ST_SD_RH : ST_SD_MOVE;
            ST_SD_RH: state_next = ST_SD_RK;
            ST_SD_RK: state_next = ST_SD_MOVE;
            ST_SD_MOVE: state_next = (midx_reg == i_reg) ? ST_CUR_RD : ST_SD_L;
            ST_CUR_RD: state_next = ST_CUR_CHK;
            ST_CUR_CHK: state_next = (s_node_reg == goal_reg) ? ST_POP : ST_EX_RD;
            ST_EX_RD: state_next = (j_reg < deg_reg) ? ST_EX_ADJ : ST_POP;
            ST_EX_ADJ: state_next = ST_EX_WK;
            ST_EX_WK: state_next = (walk_key < best_rdata) ? ST_PU_START : ST_EX_ES;
            ST_EX_ES: state_next = esc_ok ? ST_EX_EK : ST_EX_NEXT;
            ST_EX_EK: state_next = (cur_reg < best_rdata) ? ST_PU_START : ST_EX_NEXT;
            ST_EX_NEXT: state_next = ST_EX_RD;
            ST_PU_START: begin
                state_next = (count_reg >= HCW'(HEAP_DEPTH)) ? ret_reg : ST_PU_CHK;
            end
            ST_PU_CHK: state_next = (i_reg == '0) ? ret_reg : ST_PU_PH;
            ST_PU_PH: state_next = ST_PU_PK;
            ST_PU_PK: state_next = (best_rdata > pkey_reg) ? ST_PU_CHK : ret_reg;
            ST_FINISH: state_next = out_free ? ST_IDLE : ST_FINISH;
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory controls
    always_comb begin
        heap_we    = 1'b0;
        heap_waddr = '0;
        heap_wdata = '0;
        heap_raddr = '0;
        best_we    = 1'b0;
        best_waddr = '0;
        best_wdata = '0;
        best_raddr = '0;
        adj_we     = 1'b0;
        adj_waddr  = '0;
        adj_wdata  = '0;
        adj_raddr  = '0;
        deg_we     = 1'b0;
        deg_waddr  = '0;
        deg_wdata  = '0;
        deg_raddr  = '0;
        case (state_reg)
            ST_EDGE_RD_A: deg_raddr = a_idx_reg;
            ST_EDGE_WR_A: begin
                if (deg_a_val < CW'(MAX_DEGREE)) begin
                    adj_we    = 1'b1;
                    adj_waddr = {a_idx_reg, DW'(deg_a_val)};
                    adj_wdata = {b_idx_reg, len_reg, dng_reg};
                    deg_we    = 1'b1;
                    deg_waddr = a_idx_reg;
                    deg_wdata = deg_a_val + 1'b1;
                end
            end
            ST_EDGE_RD_B: deg_raddr = b_idx_reg;
            ST_EDGE_WR_B: begin
                if (deg_b_val < CW'(MAX_DEGREE)) begin
                    adj_we    = 1'b1;
                    adj_waddr = {b_idx_reg, DW'(deg_b_val)};
                    adj_wdata = {a_idx_reg, len_reg, dng_reg};
                    deg_we    = 1'b1;
                    deg_waddr = b_idx_reg;
                    deg_wdata = deg_b_val + 1'b1;
                end
            end
            ST_CLEAR: begin
                best_we    = 1'b1;
                best_waddr = clr_cnt_reg;
                best_wdata = DANGER_INF;
            end
            ST_INIT: begin
                best_we    = 1'b1;
                best_waddr = {NW'(0), start_rem_reg};
                best_wdata = '0;
                heap_we    = 1'b1;
                heap_waddr = '0;
                heap_wdata = {NW'(0), start_rem_reg};
            end
            ST_POP: heap_raddr = '0;
            ST_POP_TOP: heap_raddr = HW'(count_reg - 1'b1);
            ST_POP_XKEY: best_raddr = heap_rdata;
            ST_SD_L: heap_raddr = HW'(l_idx);
            ST_SD_LH: best_raddr = heap_rdata;
            ST_SD_R: heap_raddr = HW'(r_idx);
            ST_SD_RH: best_raddr = heap_rdata;
            ST_SD_MOVE: begin
                heap_we    = 1'b1;
                heap_waddr = HW'(i_reg);
                heap_wdata = (midx_reg == i_reg) ? x_reg : ment_reg;
            end
            ST_CUR_RD: begin
                best_raddr = {s_node_reg, m_rem_reg};
                deg_raddr  = s_node_reg;
            end
            ST_EX_RD: adj_raddr = {s_node_reg, DW'(j_reg)};
            ST_EX_ADJ: best_raddr = {adj_to, m_rem_reg};
            ST_EX_WK: begin
                if (walk_key < best_rdata) begin
                    best_we    = 1'b1;
                    best_waddr = {e_reg, m_rem_reg};
                    best_wdata = walk_key;
                end
            end
            ST_EX_ES: best_raddr = {e_reg, esc_rem};
            ST_EX_EK: begin
                if (cur_reg < best_rdata) begin
                    best_we    = 1'b1;
                    best_waddr = {e_reg, esc_rem};
                    best_wdata = cur_reg;
                end
            end
            ST_PU_CHK: begin
                if (i_reg == '0) begin
                    heap_we    = 1'b1;
                    heap_waddr = '0;
                    heap_wdata = pitem_reg;
                end else begin
                    heap_raddr = HW'(parent_idx);
                end
            end
            ST_PU_PH: best_raddr = heap_rdata;
            ST_PU_PK: begin
                heap_we    = 1'b1;
                heap_waddr = HW'(i_reg);
                heap_wdata = (best_rdata > pkey_reg) ? cand_reg : pitem_reg;
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NODE_W'(2);
            budget_reg     <= '0;
            deg_vld_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                if (paddr[2] == REG_NODE_COUNT) begin
                    node_count_reg <= pwdata[NODE_W-1:0];
                end else begin
                    budget_reg <= pwdata[LEN_W-1:0];
                end
            end
            if (deg_we) begin
                deg_vld_reg[deg_waddr] <= 1'b1;
            end
            // Hand the result over and drop the graph
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
                deg_vld_reg <= '0;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    a_idx_reg     <= NW'(s_node_a - 1'b1);
                    b_idx_reg     <= NW'(s_node_b - 1'b1);
                    len_reg       <= s_edge_length;
                    dng_reg       <= s_edge_danger;
                    goal_reg      <= NW'(goal_ext - 1'b1);
                    start_rem_reg <= (9'(budget_reg) > 9'(MAX_BUDGET - 1))
                                     ? RW'(MAX_BUDGET - 1) : RW'(budget_reg);
                    clr_cnt_reg   <= '0;
                end
            end
            ST_CLEAR: clr_cnt_reg <= clr_cnt_reg + 1'b1;
            ST_INIT: begin
                count_reg   <= HCW'(1);
                ans_reg     <= DANGER_INF;
                reached_reg <= 1'b0;
                ovf_reg     <= 1'b0;
            end
            ST_POP_TOP: begin
                s_node_reg <= heap_rdata[SW-1:RW];
                m_rem_reg  <= heap_rdata[RW-1:0];
                count_reg  <= count_reg - 1'b1;
            end
            ST_POP_XKEY: x_reg <= heap_rdata;
            ST_SD_KEYX: begin
                xkey_reg <= best_rdata;
                i_reg    <= '0;
            end
            ST_SD_L: begin
                midx_reg <= i_reg;
                mkey_reg <= xkey_reg;
                ment_reg <= x_reg;
            end
            ST_SD_LH, ST_SD_RH, ST_PU_PH: cand_reg <= heap_rdata;
            ST_SD_LK: begin
                if (best_rdata < mkey_reg) begin
                    midx_reg <= HCW'(l_idx);
                    mkey_reg <= best_rdata;
                    ment_reg <= cand_reg;
                end
            end
            ST_SD_RK: begin
                if (best_rdata < mkey_reg) begin
                    midx_reg <= HCW'(r_idx);
                    mkey_reg <= best_rdata;
                    ment_reg <= cand_reg;
                end
            end
            ST_SD_MOVE: i_reg <= midx_reg;
            ST_CUR_CHK: begin
                cur_reg <= best_rdata;
                deg_reg <= deg_s_val;
                j_reg   <= '0;
                if (s_node_reg == goal_reg && best_rdata < ans_reg) begin
                    ans_reg     <= best_rdata;
                    reached_reg <= 1'b1;
                end
            end
            ST_EX_ADJ: begin
                e_reg   <= adj_to;
                len_reg <= adj_len;
                dng_reg <= adj_dng;
            end
            ST_EX_WK: begin
                pitem_reg <= {e_reg, m_rem_reg};
                pkey_reg  <= walk_key;
                ret_reg   <= ST_EX_ES;
            end
            ST_EX_EK: begin
                pitem_reg <= {e_reg, esc_rem};
                pkey_reg  <= cur_reg;
                ret_reg   <= ST_EX_NEXT;
            end
            ST_EX_NEXT: j_reg <= j_reg + 1'b1;
            ST_PU_START: begin
                if (count_reg >= HCW'(HEAP_DEPTH)) begin
                    ovf_reg <= 1'b1;
                end else begin
                    i_reg     <= count_reg;
                    count_reg <= count_reg + 1'b1;
                end
            end
            ST_PU_PK: begin
                if (best_rdata > pkey_reg) begin
                    i_reg <= parent_idx;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_danger_reg  <= reached_reg ? ans_reg : '0;
                    m_reached_reg <= reached_reg;
                    m_ovf_reg     <= ovf_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_least_danger  = m_danger_reg;
    assign m_reached       = m_reached_reg;
    assign m_heap_overflow = m_ovf_reg;

    bspe_ram #(.WIDTH(SW), .DEPTH(HEAP_DEPTH)) u_heap_ram (
        .aclk  (aclk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    bspe_ram #(.WIDTH(DANGER_W), .DEPTH(1 << SW)) u_best_ram (
        .aclk  (aclk),
        .we    (best_we),
        .waddr (best_waddr),
        .wdata (best_wdata),
        .raddr (best_raddr),
        .rdata (best_rdata)
    );

    bspe_ram #(.WIDTH(ADJ_W), .DEPTH(1 << AW)) u_adj_ram (
        .aclk  (aclk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    bspe_ram #(.WIDTH(CW), .DEPTH(1 << NW)) u_deg_ram (
        .aclk  (aclk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

endmodule

// ===== rtl/core/bspe_checker.sv =====
module bspe_checker
    import bspe_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                s_operation,
    input logic                m_valid,
    input logic                m_ready,
    input logic [DANGER_W-1:0] m_least_danger,
    input logic                m_reached
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // Unreached goal reports zero danger
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reached |-> m_least_danger == '0)
        else $error("danger nonzero without reach");

    // Reached goal never carries the unreached mark
    a_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reached |-> m_least_danger != DANGER_INF)
        else $error("reached with infinite danger");

    // Busy right after a solve transaction
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == OP_SOLVE |=> !s_ready)
        else $error("input taken during solve");

endmodule

bind budgeted_shortest_path_engine bspe_checker u_bspe_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_operation    (s_operation),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_least_danger (m_least_danger),
    .m_reached      (m_reached)
);

// ===== tb/tb_budgeted_shortest_path_engine.sv =====
`timescale 1ns / 1ps

module tb_budgeted_shortest_path_engine;
    import bspe_pkg::*;

    localparam int NODES   = DEF_MAX_NODES;
    localparam int DEGREE  = DEF_MAX_DEGREE;
    localparam int BUDGETS = DEF_MAX_BUDGET;
    localparam int HEAP_SZ = DEF_HEAP_DEPTH;
    localparam int LIMIT_CYCLES = 100000000;

    typedef struct packed {
        logic               operation;
        logic [NODE_W-1:0]  node_a;
        logic [NODE_W-1:0]  node_b;
        logic [LEN_W-1:0]   edge_length;
        logic [DNG_W-1:0]   edge_danger;
    } path_item_t;

    typedef struct packed {
        logic [DANGER_W-1:0] least_danger;
        logic                reached;
        logic                heap_overflow;
    } path_answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_operation = 1'b0;
    logic [NODE_W-1:0] s_node_a = '0;
    logic [NODE_W-1:0] s_node_b = '0;
    logic [LEN_W-1:0] s_edge_length = '0;
    logic [DNG_W-1:0] s_edge_danger = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [DANGER_W-1:0] m_least_danger;
    logic m_reached;
    logic m_heap_overflow;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    budgeted_shortest_path_engine u_top (.*);

    always #2 aclk = ~aclk;

    // Mirror of the engine state
    logic [7:0]          cfg_node_count = 8'd2;
    logic [6:0]          cfg_budget = 7'd0;
    int unsigned         adj_to [NODES][DEGREE];
    int unsigned         adj_len [NODES][DEGREE];
    int unsigned         adj_dng [NODES][DEGREE];
    int unsigned         degree [NODES];
    int unsigned         best [NODES][BUDGETS];
    int unsigned         hp_node [HEAP_SZ];
    int unsigned         hp_rem [HEAP_SZ];
    int unsigned         hp_count;
    bit                  hp_full_seen;

    path_item_t   pending_items[$];
    path_answer_t expected_answers[$];
    path_item_t   cur_item;
    bit           item_taken = 1'b0;
    int           errors = 0;
    int           answers_seen = 0;
    longint       cycles = 0;

    function automatic int unsigned key_of(int unsigned i);
        return best[hp_node[i]][hp_rem[i]];
    endfunction

    function automatic void swap_slots(int unsigned i, int unsigned j);
        int unsigned tn;
        int unsigned tr;
        tn = hp_node[i]; tr = hp_rem[i];
        hp_node[i] = hp_node[j]; hp_rem[i] = hp_rem[j];
        hp_node[j] = tn; hp_rem[j] = tr;
    endfunction

    function automatic void heap_insert(int unsigned n, int unsigned r);
        int unsigned i;
        int unsigned p;
        if (hp_count >= HEAP_SZ) begin
            hp_full_seen = 1'b1;
            return;
        end
        i = hp_count;
        hp_count++;
        hp_node[i] = n;
        hp_rem[i] = r;
        while (i > 0) begin
            p = i >> 1;
            if (!(key_of(p) > key_of(i))) break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic bit heap_take(output int unsigned n, output int unsigned r);
        int unsigned i;
        int unsigned l;
        int unsigned m;
        n = 0; r = 0;
        if (hp_count == 0) return 1'b0;
        n = hp_node[0];
        r = hp_rem[0];
        hp_count--;
        hp_node[0] = hp_node[hp_count];
        hp_rem[0] = hp_rem[hp_count];
        i = 0;
        forever begin
            l = i << 1;
            m = i;
            if (l < hp_count && key_of(l) < key_of(i)) m = l;
            if (l + 1 < hp_count && key_of(l + 1) < key_of(m)) m = l + 1;
            if (m == i) break;
            swap_slots(i, m);
            i = m;
        end
        return 1'b1;
    endfunction

    function automatic void append_half(int unsigned from, int unsigned to,
                                        int unsigned len, int unsigned dng);
        int unsigned k;
        k = degree[from];
        if (k >= DEGREE) return;
        adj_to[from][k] = to;
        adj_len[from][k] = len;
        adj_dng[from][k] = dng;
        degree[from] = k + 1;
    endfunction

    // Run the budgeted search and clear the graph afterwards
    function automatic path_answer_t solve_least_danger();
        path_answer_t res;
        int unsigned goal;
        int unsigned start_rem;
        int unsigned s;
        int unsigned m;
        int unsigned e;
        int unsigned k;
        int unsigned cur;
        int unsigned ans;
        bit got;
        goal = (cfg_node_count == 0) ? 1 : cfg_node_count;
        if (goal > NODES) goal = NODES;
        goal -= 1;
        start_rem = (cfg_budget > BUDGETS - 1) ? BUDGETS - 1 : cfg_budget;
        foreach (best[a, b]) best[a][b] = DANGER_INF;
        hp_count = 0;
        hp_full_seen = 1'b0;
        ans = DANGER_INF;
        got = 1'b0;
        best[0][start_rem] = 0;
        heap_insert(0, start_rem);
        while (heap_take(s, m)) begin
            cur = best[s][m];
            if (s == goal) begin
                if (cur < ans) begin
                    ans = cur;
                    got = 1'b1;
                end
                continue;
            end
            for (int unsigned i = 0; i < degree[s]; i++) begin
                e = adj_to[s][i];
                k = cur + adj_dng[s][i];
                if (k > DANGER_MAX) k = DANGER_MAX;
                if (k < best[e][m]) begin
                    best[e][m] = k;
                    heap_insert(e, m);
                end
                if (adj_len[s][i] <= m) begin
                    k = m - adj_len[s][i];
                    if (cur < best[e][k]) begin
                        best[e][k] = cur;
                        heap_insert(e, k);
                    end
                end
            end
        end
        foreach (degree[i]) degree[i] = 0;
        res.least_danger = got ? ans[DANGER_W-1:0] : '0;
        res.reached = got;
        res.heap_overflow = hp_full_seen;
        return res;
    endfunction

    function automatic void apply_item(path_item_t it);
        if (it.operation == OP_ADD_EDGE) begin
            if (it.node_a == 0 || it.node_a > NODES || it.node_b == 0 || it.node_b > NODES)
                return;
            append_half(it.node_a - 1, it.node_b - 1, it.edge_length, it.edge_danger);
            append_half(it.node_b - 1, it.node_a - 1, it.edge_length, it.edge_danger);
        end else begin
            expected_answers.push_back(solve_least_danger());
        end
    endfunction

    // Hold off idling for a stretch of solves
    function automatic bit may_idle();
        return !(answers_seen >= 12 && answers_seen < 24) && ($urandom_range(0, 99) < 22);
    endfunction

    // Count cycles and stop on timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_budgeted_shortest_path_engine NOT OK");
            $finish;
        end
    end

    // Record accepted transactions and predict their results
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            apply_item(cur_item);
            item_taken = 1'b1;
        end
    end

    // Drive the input channel from the pending queue
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || item_taken)) begin
            item_taken = 1'b0;
            if (pending_items.size() > 0 && !may_idle()) begin
                cur_item = pending_items.pop_front();
                s_valid <= 1'b1;
                s_operation <= cur_item.operation;
                s_node_a <= cur_item.node_a;
                s_node_b <= cur_item.node_b;
                s_edge_length <= cur_item.edge_length;
                s_edge_danger <= cur_item.edge_danger;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_ready <= aresetn && !may_idle();
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        path_answer_t want;
        if (aresetn && m_valid && m_ready) begin
            answers_seen++;
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected result danger=%0d reached=%0b overflow=%0b",
                         $time, m_least_danger, m_reached, m_heap_overflow);
                errors++;
            end else begin
                want = expected_answers.pop_front();
                if (m_least_danger !== want.least_danger) begin
                    $display("%0t: least_danger expected %0d actual %0d",
                             $time, want.least_danger, m_least_danger);
                    errors++;
                end
                if (m_reached !== want.reached) begin
                    $display("%0t: reached expected %0b actual %0b",
                             $time, want.reached, m_reached);
                    errors++;
                end
                if (m_heap_overflow !== want.heap_overflow) begin
                    $display("%0t: heap_overflow expected %0b actual %0b",
                             $time, want.heap_overflow, m_heap_overflow);
                    errors++;
                end
            end
        end
    end

    task automatic reg_write(input logic idx, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx == REG_NODE_COUNT) cfg_node_count = value[7:0];
        else cfg_budget = value[6:0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Wait until everything sent has been answered and the engine settled
    task automatic drain();
        wait (pending_items.size() == 0 && !s_valid && expected_answers.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic configure(input int unsigned nc, input int unsigned bud);
        drain();
        reg_write(REG_NODE_COUNT, nc);
        reg_write(REG_BUDGET, bud);
    endtask

    task automatic queue_edge(input int unsigned a, input int unsigned b,
                              input int unsigned len, input int unsigned dng);
        path_item_t it;
        it.operation = OP_ADD_EDGE;
        it.node_a = NODE_W'(a);
        it.node_b = NODE_W'(b);
        it.edge_length = LEN_W'(len);
        it.edge_danger = DNG_W'(dng);
        pending_items.push_back(it);
    endtask

    task automatic queue_solve();
        path_item_t it;
        it.operation = OP_SOLVE;
        it.node_a = NODE_W'($urandom);
        it.node_b = NODE_W'($urandom);
        it.edge_length = LEN_W'($urandom);
        it.edge_danger = DNG_W'($urandom);
        pending_items.push_back(it);
    endtask

    // Random graph on the first span nodes with some stray endpoints, then a solve
    task automatic queue_graph(input int unsigned span, input int unsigned n_edges,
                               input bit long_edges);
        int unsigned a;
        int unsigned b;
        int unsigned len;
        int unsigned dng;
        for (int i = 0; i < n_edges; i++) begin
            a = $urandom_range(1, span);
            b = $urandom_range(1, span);
            if ($urandom_range(0, 19) == 0) a = $urandom_range(0, 255);
            if ($urandom_range(0, 19) == 0) b = $urandom_range(0, 255);
            len = (!long_edges && $urandom_range(0, 2) == 0) ? $urandom_range(0, 4)
                                                             : $urandom_range(0, 127);
            dng = ($urandom_range(0, 9) == 0) ? 16383 : $urandom_range(0, 16383);
            queue_edge(a, b, len, dng);
        end
        queue_solve();
    endtask

    initial begin
        int unsigned nc;
        int unsigned bud;
        int unsigned span;
        int items_sent;
        bit wide_budget;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, ignored endpoints, self loop, zero-length escort
        configure(4, 3);
        queue_edge(1, 2, 0, 0);
        queue_edge(2, 3, 127, 16383);
        queue_edge(3, 4, 5, 100);
        queue_edge(3, 4, 2, 9000);
        queue_edge(0, 2, 1, 1);
        queue_edge(129, 1, 1, 1);
        queue_edge(255, 255, 1, 1);
        queue_edge(1, 0, 1, 1);
        queue_edge(2, 2, 1, 7);
        queue_edge(1, 128, 127, 16383);
        queue_solve();
        // graph was cleared, so the goal is unreachable
        queue_solve();

        // Zero node count: goal is the start
        configure(0, 127);
        queue_edge(1, 2, 3, 50);
        queue_solve();

        // Oversized node count saturates to the last node
        configure(255, 127);
        queue_edge(1, 128, 127, 16383);
        queue_edge(128, 1, 0, 1);
        queue_edge(1, 64, 1, 10);
        queue_edge(64, 128, 127, 16383);
        queue_solve();

        configure(1, 0);
        queue_solve();

        // Full adjacency list on node 1: later halves dropped
        configure(3, 0);
        for (int i = 0; i < DEGREE + 2; i++)
            queue_edge(1, 2, $urandom_range(0, 127), $urandom_range(0, 16383));
        queue_edge(1, 3, 0, 5);
        queue_edge(2, 3, 0, 5);
        queue_solve();

        // Random phases of graphs with some stray endpoints, followed by solves
        items_sent = 0;
        while (items_sent < 1850) begin
            case ($urandom_range(0, 9))
                0: nc = $urandom_range(0, 1);
                1: nc = $urandom_range(128, 255);
                default: nc = $urandom_range(2, 10);
            endcase
            wide_budget = ($urandom_range(0, 9) == 0);
            bud = wide_budget ? $urandom_range(64, 127) : $urandom_range(0, 15);
            configure(nc, bud);
            span = (nc < 2) ? 4 : (nc > 10 ? 12 : nc + 2);
            for (int g = $urandom_range(1, 3); g > 0; g--) begin
                int n_edges;
                n_edges = $urandom_range(1, 40);
                if (nc > 10) begin
                    // long edge toward the last node
                    queue_edge(span, NODES, $urandom_range(0, 127), $urandom_range(0, 16383));
                    items_sent++;
                end
                queue_graph(span, n_edges, wide_budget);
                items_sent += n_edges + 1;
            end
        end

        drain();
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_budgeted_shortest_path_engine OK");
        end else begin
            $display("tb_budgeted_shortest_path_engine NOT OK");
        end
        $finish;
    end

endmodule
